// ----- hdl/ase_pkg.sv -----
// Shared constants, state encoding and control/status types for the arctanh series evaluator.
package ase_pkg;

  localparam int unsigned FRAC_BITS  = 30;
  localparam int unsigned X_W        = FRAC_BITS + 1;
  localparam int unsigned PREC_W     = 30;
  localparam int unsigned SUM_MAG_W  = 35;
  localparam int unsigned SUM_W      = SUM_MAG_W + 1;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned PROD_W     = 2 * FRAC_BITS;
  localparam int unsigned DIV_STEPS  = X_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(1073742);
  localparam logic [PROD_W-1:0] RND_HALF   = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR_MUL,
    S_SQR_RND,
    S_DIV_INIT,
    S_DIV,
    S_ACC,
    S_PWR_MUL,
    S_PWR_RND
  } ase_state_e;

  typedef struct packed {
    logic load;
    logic sqr_mul;
    logic sqr_rnd;
    logic div_init;
    logic div_step;
    logic acc;
    logic finish;
    logic pwr_mul;
    logic pwr_rnd;
  } ase_cmd_t;

  typedef struct packed {
    logic div_last;
    logic t_small;
    logic at_limit;
  } ase_sts_t;

endpackage

// ----- hdl/ase_ctrl.sv -----
// Sequencer for the series: square, then per term divide, accumulate, next odd power.
module ase_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  ase_pkg::ase_sts_t sts_i,
  output ase_pkg::ase_cmd_t cmd_o,
  output logic              busy
);

  ase_pkg::ase_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ase_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ase_pkg::S_IDLE: begin
        if (start) state_d = ase_pkg::S_SQR_MUL;
      end
      ase_pkg::S_SQR_MUL:  state_d = ase_pkg::S_SQR_RND;
      ase_pkg::S_SQR_RND:  state_d = ase_pkg::S_DIV_INIT;
      ase_pkg::S_DIV_INIT: state_d = ase_pkg::S_DIV;
      ase_pkg::S_DIV: begin
        if (sts_i.div_last) state_d = ase_pkg::S_ACC;
      end
      ase_pkg::S_ACC: begin
        if (sts_i.t_small || sts_i.at_limit) state_d = ase_pkg::S_IDLE;
        else state_d = ase_pkg::S_PWR_MUL;
      end
      ase_pkg::S_PWR_MUL:  state_d = ase_pkg::S_PWR_RND;
      ase_pkg::S_PWR_RND:  state_d = ase_pkg::S_DIV_INIT;
      default:             state_d = ase_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ase_pkg::S_IDLE:     cmd_o.load     = start;
      ase_pkg::S_SQR_MUL:  cmd_o.sqr_mul  = 1'b1;
      ase_pkg::S_SQR_RND:  cmd_o.sqr_rnd  = 1'b1;
      ase_pkg::S_DIV_INIT: cmd_o.div_init = 1'b1;
      ase_pkg::S_DIV:      cmd_o.div_step = 1'b1;
      ase_pkg::S_ACC: begin
        cmd_o.acc    = 1'b1;
        cmd_o.finish = sts_i.t_small || sts_i.at_limit;
      end
      ase_pkg::S_PWR_MUL:  cmd_o.pwr_mul  = 1'b1;
      ase_pkg::S_PWR_RND:  cmd_o.pwr_rnd  = 1'b1;
      default:             cmd_o = '0;
    endcase
  end

  assign busy = (state_q != ase_pkg::S_IDLE);

endmodule

// ----- hdl/ase_dp.sv -----
// Datapath: shared 30x30 multiplier, radix-2 term divider, saturating accumulator, result word.
module ase_dp #(
  parameter int unsigned MAX_TERMS = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ase_pkg::ase_cmd_t                     cmd_i,
  output ase_pkg::ase_sts_t                     sts_o,
  input  logic signed [ase_pkg::X_W-1:0]        x_value_i,
  input  logic                                  precision_we_i,
  input  logic        [ase_pkg::PREC_W-1:0]     precision_i,
  output logic signed [ase_pkg::SUM_W-1:0]      sum_value_o,
  output logic        [ase_pkg::CNT_W-1:0]      term_count_o,
  output logic                                  converged_o,
  output logic                                  result_valid_o
);

  localparam int unsigned KW  = $clog2(MAX_TERMS);
  localparam int unsigned CW  = $clog2(MAX_TERMS + 1);
  localparam int unsigned DVW = KW + 1;
  localparam int unsigned F   = ase_pkg::FRAC_BITS;

  logic                          neg_q;
  logic [F-1:0]                  m_q, m2_q, p_q;
  logic [ase_pkg::PROD_W-1:0]    prod_q;
  logic [KW-1:0]                 k_q;
  logic [ase_pkg::SUM_MAG_W-1:0] sum_q;
  logic [ase_pkg::X_W-1:0]       quo_q;
  logic [DVW-1:0]                rem_q;
  logic [ase_pkg::STEP_W-1:0]    step_q;
  logic [ase_pkg::PREC_W-1:0]    precision_q;
  logic [ase_pkg::SUM_W-1:0]     sum_value_q;
  logic [ase_pkg::CNT_W-1:0]     term_count_q;
  logic                          converged_q;
  logic                          valid_q;

  logic [ase_pkg::X_W-1:0]       x_raw, mag;
  logic [F-1:0]                  m_clamp, mul_a, mul_b, rnd;
  logic [ase_pkg::PROD_W-1:0]    product, rnd_full;
  logic [DVW-1:0]                divisor, rem_next;
  logic [DVW:0]                  rem_sh, rem_sub;
  logic                          sub_ok;
  logic [ase_pkg::X_W-1:0]       dividend;
  logic [ase_pkg::SUM_MAG_W:0]   sum_wide;
  logic [ase_pkg::SUM_MAG_W-1:0] sum_next;
  logic [ase_pkg::SUM_W-1:0]     sum_mag_ext, sum_signed;
  logic [CW-1:0]                 cnt_next;

  // magnitude of x, clamped just below one
  assign x_raw   = x_value_i;
  assign mag     = x_raw[ase_pkg::X_W-1] ? (ase_pkg::X_W'(0) - x_raw) : x_raw;
  assign m_clamp = mag[ase_pkg::X_W-1] ? '1 : mag[F-1:0];

  assign mul_a    = cmd_i.sqr_mul ? m_q : p_q;
  assign mul_b    = cmd_i.sqr_mul ? m_q : m2_q;
  assign product  = ase_pkg::PROD_W'(mul_a) * ase_pkg::PROD_W'(mul_b);
  assign rnd_full = prod_q + ase_pkg::RND_HALF;
  assign rnd      = rnd_full[2*F-1:F];

  // term = (p + k) / (2k + 1), restoring division one quotient bit a cycle
  assign divisor  = {k_q, 1'b1};
  assign dividend = ase_pkg::X_W'(p_q) + ase_pkg::X_W'(k_q);
  assign rem_sh   = {rem_q, quo_q[ase_pkg::X_W-1]};
  assign sub_ok   = (rem_sh >= (DVW+1)'(divisor));
  assign rem_sub  = rem_sh - (DVW+1)'(divisor);
  assign rem_next = sub_ok ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];

  assign sum_wide    = (ase_pkg::SUM_MAG_W+1)'(sum_q) + (ase_pkg::SUM_MAG_W+1)'(quo_q);
  assign sum_next    = sum_wide[ase_pkg::SUM_MAG_W] ? '1 : sum_wide[ase_pkg::SUM_MAG_W-1:0];
  assign sum_mag_ext = {1'b0, sum_next};
  assign sum_signed  = neg_q ? (ase_pkg::SUM_W'(0) - sum_mag_ext) : sum_mag_ext;
  assign cnt_next    = CW'(k_q) + CW'(1);

  assign sts_o.div_last = (step_q == ase_pkg::STEP_W'(1));
  assign sts_o.t_small  = (quo_q < ase_pkg::X_W'(precision_q));
  assign sts_o.at_limit = (k_q == KW'(MAX_TERMS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_q <= ase_pkg::PREC_RESET;
      valid_q     <= 1'b0;
    end else begin
      if (precision_we_i) precision_q <= precision_i;
      valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= x_raw[ase_pkg::X_W-1];
      m_q   <= m_clamp;
      p_q   <= m_clamp;
      k_q   <= '0;
      sum_q <= '0;
    end
    if (cmd_i.sqr_mul || cmd_i.pwr_mul) prod_q <= product;
    if (cmd_i.sqr_rnd) m2_q <= rnd;
    if (cmd_i.pwr_rnd) begin
      p_q <= rnd;
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.div_init) begin
      quo_q  <= dividend;
      rem_q  <= '0;
      step_q <= ase_pkg::STEP_W'(ase_pkg::DIV_STEPS);
    end
    if (cmd_i.div_step) begin
      quo_q  <= {quo_q[ase_pkg::X_W-2:0], sub_ok};
      rem_q  <= rem_next;
      step_q <= step_q - ase_pkg::STEP_W'(1);
    end
    if (cmd_i.acc) sum_q <= sum_next;
    if (cmd_i.finish) begin
      sum_value_q  <= sum_signed;
      term_count_q <= ase_pkg::CNT_W'(cnt_next);
      converged_q  <= sts_o.t_small;
    end
  end

  assign sum_value_o    = $signed(sum_value_q);
  assign term_count_o   = term_count_q;
  assign converged_o    = converged_q;
  assign result_valid_o = valid_q;

endmodule

// ----- hdl/arctanh_series_evaluator.sv -----
// Per word: load x and square it on the shared multiplier, then per term run the radix-2 divider,
//   accumulate, and form the next odd power on the shared multiplier (multiply, then round).
//   No new word is taken until the series ends, on a small term or after MAX_TERMS terms.
// start is taken again in the cycle the result strobe is high; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns to idle, drops the strobe and restores precision.
module arctanh_series_evaluator #(
  parameter int unsigned MAX_TERMS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ase_pkg::X_W-1:0]    x_value_i,
  input  logic                              precision_we_i,
  input  logic        [ase_pkg::PREC_W-1:0] precision_i,
  output logic                              result_valid_o,
  output logic signed [ase_pkg::SUM_W-1:0]  sum_value_o,
  output logic        [ase_pkg::CNT_W-1:0]  term_count_o,
  output logic                              converged_o
);

  ase_pkg::ase_cmd_t cmd;
  ase_pkg::ase_sts_t sts;
  logic              ctrl_busy;

  ase_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (ctrl_busy)
  );

  ase_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .x_value_i      (x_value_i),
    .precision_we_i (precision_we_i),
    .precision_i    (precision_i),
    .sum_value_o    (sum_value_o),
    .term_count_o   (term_count_o),
    .converged_o    (converged_o),
    .result_valid_o (result_valid_o)
  );

  assign busy = ctrl_busy;

endmodule

// ----- hdl/ase_checker.sv -----
// Port-level checks for the arctanh series evaluator, bound to the top level.
module ase_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(busy))
    else $error("result strobe outside the end of a busy run");

  a_fell_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy ended without a result word");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind arctanh_series_evaluator ase_checker u_ase_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
